### design/rri_pkg.sv
// ----------------------------------------------------------------------------
// rri_pkg
// Shared widths, payload types and helpers for the ray / rectangle
// intersection pipeline.
// ----------------------------------------------------------------------------
package rri_pkg;

    localparam int COORD_WIDTH     = 20;
    localparam int DIST_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int EPS_WIDTH       = 10;
    localparam int NRM_SHIFT       = 10;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 3 * COORD_WIDTH;

    // normal component after the Q20.20 -> Q20.10 shift
    localparam int NRM_WIDTH = 2 * COORD_WIDTH - NRM_SHIFT + 1;
    localparam int DEN_WIDTH = NRM_WIDTH + COORD_WIDTH + 2;
    localparam int NUM_WIDTH = NRM_WIDTH + COORD_WIDTH + 3;
    localparam int REM_WIDTH = DEN_WIDTH + 1;
    localparam int SAT_SHIFT = DIST_WIDTH - FRAC_BITS;
    localparam int CMP_WIDTH = DEN_WIDTH + SAT_SHIFT + 1;
    localparam int OFS_WIDTH = COORD_WIDTH + DIST_WIDTH + 1;
    localparam int PNT_WIDTH = COORD_WIDTH + 4;
    localparam int PRJ_WIDTH = PNT_WIDTH + COORD_WIDTH + 2;
    localparam int LEN_WIDTH = 2 * COORD_WIDTH + 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CENTER  = 4'd0,
        REG_HALF_U  = 4'd1,
        REG_HALF_V  = 4'd2,
        REG_EPSILON = 4'd3
    } cfg_reg_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t ray_start_x;
        coord_t ray_start_y;
        coord_t ray_start_z;
        coord_t ray_dir_x;
        coord_t ray_dir_y;
        coord_t ray_dir_z;
    } rri_in_t;

    typedef struct packed {
        logic                  hit;
        logic [DIST_WIDTH-1:0] hit_distance;
    } rri_out_t;

    // ray data and early-out flags that ride along the divider
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t rx;
        coord_t ry;
        coord_t rz;
        logic   miss;
        logic   sat;
    } rri_side_t;

    function automatic logic signed [PNT_WIDTH-1:0] clamp_pnt(
        input logic signed [OFS_WIDTH:0] x
    );
        logic signed [OFS_WIDTH:0] lim;
        lim = (OFS_WIDTH+1)'(1);
        lim = lim <<< (COORD_WIDTH + 2);
        if (x > lim)
            return PNT_WIDTH'(lim);
        else if (x < -lim)
            return PNT_WIDTH'(-lim);
        else
            return PNT_WIDTH'(x);
    endfunction

endpackage

### design/rri_divider.sv
// ----------------------------------------------------------------------------
// rri_divider
// Pipelined restoring divider, one quotient bit per stage. Produces
// floor(num * 2^FRAC_BITS / den) over DIST_WIDTH bits; ray data rides along.
// ----------------------------------------------------------------------------
module rri_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rri_pkg::NUM_WIDTH-1:0]  in_num,
    input  logic [rri_pkg::DEN_WIDTH-1:0]  in_den,
    input  rri_pkg::rri_side_t          in_side,
    output logic                        out_valid,
    output logic [rri_pkg::DIST_WIDTH-1:0] out_quo,
    output rri_pkg::rri_side_t          out_side
);
    import rri_pkg::*;

    logic                  valid_reg [1:DIST_WIDTH];
    logic [REM_WIDTH-1:0]  rem_reg   [1:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] low_reg   [1:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] quo_reg   [1:DIST_WIDTH];
    logic [DEN_WIDTH-1:0]  den_reg   [1:DIST_WIDTH];
    rri_side_t             side_reg  [1:DIST_WIDTH];

    for (genvar k = 0; k < DIST_WIDTH; k++)
    begin : g_stage
        logic                  valid_in;
        logic [REM_WIDTH-1:0]  rem_in;
        logic [DIST_WIDTH-1:0] low_in;
        logic [DIST_WIDTH-1:0] quo_in;
        logic [DEN_WIDTH-1:0]  den_in;
        rri_side_t             side_in;
        logic [REM_WIDTH-1:0]  trial;
        logic                  take;

        // stage 0 takes the input itself
        if (k == 0)
        begin : g_head
            assign valid_in = in_valid;
            assign rem_in   = REM_WIDTH'(in_num >> SAT_SHIFT);
            assign low_in   = DIST_WIDTH'({in_num, {FRAC_BITS{1'b0}}});
            assign quo_in   = '0;
            assign den_in   = in_den;
            assign side_in  = in_side;
        end
        else
        begin : g_body
            assign valid_in = valid_reg[k];
            assign rem_in   = rem_reg[k];
            assign low_in   = low_reg[k];
            assign quo_in   = quo_reg[k];
            assign den_in   = den_reg[k];
            assign side_in  = side_reg[k];
        end

        always_comb
        begin
            trial = {rem_in[REM_WIDTH-2:0], low_in[DIST_WIDTH-1]};
            take  = trial >= REM_WIDTH'(den_in);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? trial - REM_WIDTH'(den_in) : trial;
                low_reg[k+1]  <= {low_in[DIST_WIDTH-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_in[DIST_WIDTH-2:0], take};
                den_reg[k+1]  <= den_in;
                side_reg[k+1] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[DIST_WIDTH];
    assign out_quo   = quo_reg[DIST_WIDTH];
    assign out_side  = side_reg[DIST_WIDTH];

endmodule

### design/ray_rectangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_rectangle_intersect
// Fixed-point ray / rectangle hit test with saturating Q16.16 distance.
// ----------------------------------------------------------------------------
// Takes one ray per clock while ray_stall is low and returns one result per ray,
// in order. The depth is set by the hit-distance divider, one quotient bit per
// stage (32 stages), plus five stages ahead of it (ray latch, normal products,
// dot sums, magnitudes, saturation check) and seven after it (distance select,
// direction scaling, hit point, projections, edge compare, output register). A
// stall of a valid result freezes the whole pipeline and is passed back as
// ray_stall in the same cycle. Configuration writes are always ready; the
// derived normal and edge lengths settle in the cycle after a write, so write
// only while no ray is in flight.
module ray_rectangle_intersect (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rri_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rri_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                ray_valid,
    output logic                                ray_stall,
    input  rri_pkg::rri_in_t                    ray,
    output logic                                res_valid,
    input  logic                                res_stall,
    output rri_pkg::rri_out_t                   res
);
    import rri_pkg::*;

    logic en;

    // configuration
    logic [CFG_DATA_WIDTH-1:0] center_reg, half_u_reg, half_v_reg;
    logic [EPS_WIDTH-1:0]      eps_reg;
    coord_t cx, cy, cz, ux, uy, uz, vx, vy, vz;

    logic signed [NRM_WIDTH-1:0] nrm_x_reg, nrm_y_reg, nrm_z_reg;
    logic [LEN_WIDTH-1:0]        len_u_reg, len_v_reg;
    logic signed [2*COORD_WIDTH:0] crs_x, crs_y, crs_z;
    logic signed [LEN_WIDTH-1:0]   sq_u, sq_v;

    // pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg, res_valid_reg;

    rri_side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    rri_side_t side6_reg, side7_reg;
    rri_side_t side4_next, side5_next, side6_next;
    logic signed [COORD_WIDTH:0] csx1_reg, csy1_reg, csz1_reg;

    logic signed [NRM_WIDTH+COORD_WIDTH-1:0] pdx2_reg, pdy2_reg, pdz2_reg;
    logic signed [NRM_WIDTH+COORD_WIDTH:0]   pnx2_reg, pny2_reg, pnz2_reg;

    logic signed [DEN_WIDTH-1:0] den3_reg;
    logic signed [NUM_WIDTH-1:0] num3_reg;

    logic [NUM_WIDTH-1:0] a4_reg;
    logic [DEN_WIDTH-1:0] b4_reg;

    logic [NUM_WIDTH-1:0] a5_reg;
    logic [DEN_WIDTH-1:0] b5_reg;

    logic                  dv_valid;
    logic [DIST_WIDTH-1:0] dv_quo;
    rri_side_t             dv_side;
    logic [DIST_WIDTH-1:0] t_sel;

    logic [DIST_WIDTH-1:0] t6_reg, t7_reg, t8_reg, t9_reg, t10_reg, t11_reg;
    logic miss7_reg, miss8_reg, miss9_reg, miss10_reg, miss11_reg;
    logic signed [DIST_WIDTH:0]  t_signed;
    logic signed [OFS_WIDTH-1:0] ofx7_reg, ofy7_reg, ofz7_reg;
    logic signed [OFS_WIDTH:0]   hpx, hpy, hpz;
    logic signed [PNT_WIDTH-1:0] px8_reg, py8_reg, pz8_reg;
    logic signed [PNT_WIDTH+COORD_WIDTH-1:0] pux9_reg, puy9_reg, puz9_reg;
    logic signed [PNT_WIDTH+COORD_WIDTH-1:0] pvx9_reg, pvy9_reg, pvz9_reg;
    logic signed [PRJ_WIDTH-1:0] pu10_reg, pv10_reg;
    logic [PRJ_WIDTH-1:0]        au11_reg, av11_reg;
    logic                        inside_u, inside_v;
    rri_out_t                    res_reg;

    assign cfg_ready = 1'b1;
    assign en        = !(res_valid_reg && res_stall);
    assign ray_stall = !en;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            half_u_reg <= '0;
            half_v_reg <= '0;
            eps_reg    <= EPS_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CENTER:  center_reg <= cfg_data;
                REG_HALF_U:  half_u_reg <= cfg_data;
                REG_HALF_V:  half_v_reg <= cfg_data;
                REG_EPSILON: eps_reg    <= cfg_data[EPS_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        cx = center_reg[0*COORD_WIDTH +: COORD_WIDTH];
        cy = center_reg[1*COORD_WIDTH +: COORD_WIDTH];
        cz = center_reg[2*COORD_WIDTH +: COORD_WIDTH];
        ux = half_u_reg[0*COORD_WIDTH +: COORD_WIDTH];
        uy = half_u_reg[1*COORD_WIDTH +: COORD_WIDTH];
        uz = half_u_reg[2*COORD_WIDTH +: COORD_WIDTH];
        vx = half_v_reg[0*COORD_WIDTH +: COORD_WIDTH];
        vy = half_v_reg[1*COORD_WIDTH +: COORD_WIDTH];
        vz = half_v_reg[2*COORD_WIDTH +: COORD_WIDTH];
        crs_x = uy * vz - uz * vy;
        crs_y = uz * vx - ux * vz;
        crs_z = ux * vy - uy * vx;
        sq_u  = ux * ux + uy * uy + uz * uz;
        sq_v  = vx * vx + vy * vy + vz * vz;
    end

    // normal and squared edge lengths follow the config registers
    always_ff @(posedge clk)
    begin
        nrm_x_reg <= NRM_WIDTH'(crs_x >>> NRM_SHIFT);
        nrm_y_reg <= NRM_WIDTH'(crs_y >>> NRM_SHIFT);
        nrm_z_reg <= NRM_WIDTH'(crs_z >>> NRM_SHIFT);
        len_u_reg <= sq_u;
        len_v_reg <= sq_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= ray_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= dv_valid;
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            res_valid_reg <= v11_reg;
        end
    end

    always_comb
    begin
        // zero denominator, hit behind start
        side4_next      = side3_reg;
        side4_next.miss = (den3_reg == '0) ||
                          ((num3_reg != '0) &&
                           (num3_reg[NUM_WIDTH-1] != den3_reg[DEN_WIDTH-1]));
        // near-parallel test and distance overflow
        side5_next      = side4_reg;
        side5_next.miss = side4_reg.miss || (b4_reg < DEN_WIDTH'(eps_reg));
        side5_next.sat  = CMP_WIDTH'(a4_reg) >= (CMP_WIDTH'(b4_reg) << SAT_SHIFT);
        // saturate, near-hit test
        t_sel           = dv_side.sat ? {DIST_WIDTH{1'b1}} : dv_quo;
        side6_next      = dv_side;
        side6_next.miss = dv_side.miss || (t_sel < DIST_WIDTH'(eps_reg));
        t_signed = signed'({1'b0, t6_reg});
        hpx = side7_reg.sx + (ofx7_reg >>> FRAC_BITS) - cx;
        hpy = side7_reg.sy + (ofy7_reg >>> FRAC_BITS) - cy;
        hpz = side7_reg.sz + (ofz7_reg >>> FRAC_BITS) - cz;
        inside_u = ((PRJ_WIDTH+1)'(au11_reg) + (PRJ_WIDTH+1)'(eps_reg))
                   < (PRJ_WIDTH+1)'(len_u_reg);
        inside_v = ((PRJ_WIDTH+1)'(av11_reg) + (PRJ_WIDTH+1)'(eps_reg))
                   < (PRJ_WIDTH+1)'(len_v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // S1: latch ray, center minus start
            side1_reg.sx   <= ray.ray_start_x;
            side1_reg.sy   <= ray.ray_start_y;
            side1_reg.sz   <= ray.ray_start_z;
            side1_reg.rx   <= ray.ray_dir_x;
            side1_reg.ry   <= ray.ray_dir_y;
            side1_reg.rz   <= ray.ray_dir_z;
            side1_reg.miss <= 1'b0;
            side1_reg.sat  <= 1'b0;
            csx1_reg <= cx - ray.ray_start_x;
            csy1_reg <= cy - ray.ray_start_y;
            csz1_reg <= cz - ray.ray_start_z;

            // S2: normal products
            side2_reg <= side1_reg;
            pdx2_reg  <= nrm_x_reg * side1_reg.rx;
            pdy2_reg  <= nrm_y_reg * side1_reg.ry;
            pdz2_reg  <= nrm_z_reg * side1_reg.rz;
            pnx2_reg  <= nrm_x_reg * csx1_reg;
            pny2_reg  <= nrm_y_reg * csy1_reg;
            pnz2_reg  <= nrm_z_reg * csz1_reg;

            // S3: denominator and numerator
            side3_reg <= side2_reg;
            den3_reg  <= pdx2_reg + pdy2_reg + pdz2_reg;
            num3_reg  <= pnx2_reg + pny2_reg + pnz2_reg;

            // S4: magnitudes, zero denominator, hit behind start
            side4_reg <= side4_next;
            a4_reg <= num3_reg[NUM_WIDTH-1] ? NUM_WIDTH'(-num3_reg) : num3_reg;
            b4_reg <= den3_reg[DEN_WIDTH-1] ? DEN_WIDTH'(-den3_reg) : den3_reg;

            // S5: near-parallel test and distance overflow
            side5_reg <= side5_next;
            a5_reg <= a4_reg;
            b5_reg <= b4_reg;

            // S6: saturate, near-hit test
            side6_reg <= side6_next;
            t6_reg    <= t_sel;

            // S7: scale direction by t
            side7_reg <= side6_reg;
            miss7_reg <= side6_reg.miss;
            t7_reg    <= t6_reg;
            ofx7_reg  <= side6_reg.rx * t_signed;
            ofy7_reg  <= side6_reg.ry * t_signed;
            ofz7_reg  <= side6_reg.rz * t_signed;

            // S8: hit point relative to center, clamped
            miss8_reg <= miss7_reg;
            t8_reg    <= t7_reg;
            px8_reg   <= clamp_pnt(hpx);
            py8_reg   <= clamp_pnt(hpy);
            pz8_reg   <= clamp_pnt(hpz);

            // S9: projection products
            miss9_reg <= miss8_reg;
            t9_reg    <= t8_reg;
            pux9_reg  <= px8_reg * ux;
            puy9_reg  <= py8_reg * uy;
            puz9_reg  <= pz8_reg * uz;
            pvx9_reg  <= px8_reg * vx;
            pvy9_reg  <= py8_reg * vy;
            pvz9_reg  <= pz8_reg * vz;

            // S10: projection sums
            miss10_reg <= miss9_reg;
            t10_reg    <= t9_reg;
            pu10_reg   <= pux9_reg + puy9_reg + puz9_reg;
            pv10_reg   <= pvx9_reg + pvy9_reg + pvz9_reg;

            // S11: projection magnitudes
            miss11_reg <= miss10_reg;
            t11_reg    <= t10_reg;
            au11_reg   <= pu10_reg[PRJ_WIDTH-1] ? PRJ_WIDTH'(-pu10_reg) : pu10_reg;
            av11_reg   <= pv10_reg[PRJ_WIDTH-1] ? PRJ_WIDTH'(-pv10_reg) : pv10_reg;

            // S12: edge test and result
            res_reg.hit          <= !miss11_reg && inside_u && inside_v;
            res_reg.hit_distance <= (!miss11_reg && inside_u && inside_v) ?
                                    t11_reg : '0;
        end
    end

    rri_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (a5_reg),
        .in_den    (b5_reg),
        .in_side   (side5_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

endmodule

### design/rri_checker.sv
// ----------------------------------------------------------------------------
// rri_checker
// Port-level checks for ray_rectangle_intersect, bound to the top level.
// ----------------------------------------------------------------------------
module rri_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              ray_stall,
    input logic              res_valid,
    input logic              res_stall,
    input rri_pkg::rri_out_t res
);
    import rri_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // ray side only stalls on a stalled pending result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall |-> res_valid && res_stall)
        else $error("ray stalled without output backpressure");

    // a miss carries zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.hit_distance == '0)
        else $error("nonzero distance on miss");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

endmodule

bind ray_rectangle_intersect rri_checker u_rri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray_stall (ray_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

### tb/ray_rectangle_intersect_check.sv
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_check
// Watches ray and result transfers, predicts each result from the current
// rectangle settings and compares in order.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_check
    import rri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic      ray_valid,
    input  logic      ray_stall,
    input  rri_in_t   ray,
    input  logic      res_valid,
    input  logic      res_stall,
    input  rri_out_t  res,
    output int        fail_count,
    output int        pending,
    output int        hit_count,
    output int        result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    logic [CFG_DATA_WIDTH-1:0] center_q, edge_u_q, edge_v_q;
    logic [EPS_WIDTH-1:0]      eps_q;
    rri_out_t                  expected_q[$];

    function automatic longint sx(logic [COORD_WIDTH-1:0] w);
        return longint'($signed(w));
    endfunction

    function automatic vec_t unpack_vec(logic [CFG_DATA_WIDTH-1:0] p);
        vec_t r;
        r.x = sx(p[COORD_WIDTH-1:0]);
        r.y = sx(p[2*COORD_WIDTH-1:COORD_WIDTH]);
        r.z = sx(p[3*COORD_WIDTH-1:2*COORD_WIDTH]);
        return r;
    endfunction

    function automatic longint dotp(vec_t a, vec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    // arithmetic shift floors toward minus infinity
    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clamp_point(longint x);
        longint lim;
        lim = longint'(1) <<< (COORD_WIDTH + 2);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    function automatic longint scaled_dir(longint dir, longint t);
        return dir * (t >>> 16) + floor_shift(dir * (t & 64'hFFFF), 16);
    endfunction

    function automatic longint absv(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic rri_out_t predict_hit(rri_in_t r);
        rri_out_t o;
        vec_t     c, u, v, s, dv, n, cs, p;
        longint   den, num, a, b, q, rem, t, eps, pu, pv;
        longint   dmax;
        int       i;
        o = '0;
        dmax = (longint'(1) <<< DIST_WIDTH) - 1;
        eps = longint'(eps_q);
        c = unpack_vec(center_q);
        u = unpack_vec(edge_u_q);
        v = unpack_vec(edge_v_q);
        s.x = r.ray_start_x; s.y = r.ray_start_y; s.z = r.ray_start_z;
        dv.x = r.ray_dir_x;  dv.y = r.ray_dir_y;  dv.z = r.ray_dir_z;
        n.x = floor_shift(u.y * v.z - u.z * v.y, NRM_SHIFT);
        n.y = floor_shift(u.z * v.x - u.x * v.z, NRM_SHIFT);
        n.z = floor_shift(u.x * v.y - u.y * v.x, NRM_SHIFT);
        den = dotp(n, dv);
        if (den == 0 || absv(den) < eps)
            return o;
        cs.x = c.x - s.x; cs.y = c.y - s.y; cs.z = c.z - s.z;
        num = dotp(n, cs);
        if (num != 0 && ((num < 0) != (den < 0)))
            return o;
        a = absv(num);
        b = absv(den);
        q = a / b;
        rem = a % b;
        if (q > (dmax >>> 16))
            t = dmax;
        else
        begin
            // one fraction bit at a time keeps the remainder within 64 bits
            t = q;
            for (i = 0; i < 16; i++)
            begin
                rem = rem <<< 1;
                t = t <<< 1;
                if (rem >= b)
                begin
                    rem = rem - b;
                    t = t | 1;
                end
            end
        end
        if (t < eps)
            return o;
        p.x = clamp_point(s.x + scaled_dir(dv.x, t) - c.x);
        p.y = clamp_point(s.y + scaled_dir(dv.y, t) - c.y);
        p.z = clamp_point(s.z + scaled_dir(dv.z, t) - c.z);
        pu = dotp(p, u);
        pv = dotp(p, v);
        if (absv(pu) + eps < dotp(u, u) && absv(pv) + eps < dotp(v, v))
        begin
            o.hit = 1'b1;
            o.hit_distance = DIST_WIDTH'(t);
        end
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_q <= '0;
            edge_u_q <= '0;
            edge_v_q <= '0;
            eps_q <= EPS_WIDTH'(1);
            fail_count <= 0;
            hit_count <= 0;
            result_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CENTER:  center_q <= cfg_data;
                    REG_HALF_U:  edge_u_q <= cfg_data;
                    REG_HALF_V:  edge_v_q <= cfg_data;
                    REG_EPSILON: eps_q <= cfg_data[EPS_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (ray_valid && !ray_stall)
                expected_q.push_back(predict_hit(ray));
            if (res_valid && !res_stall)
            begin
                result_count <= result_count + 1;
                if (res.hit)
                    hit_count <= hit_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: hit=%0b t=%0h",
                             $time, res.hit, res.hit_distance);
                    fail_count <= fail_count + 1;
                end
                else if (res.hit !== expected_q[0].hit
                         || res.hit_distance !== expected_q[0].hit_distance)
                begin
                    $display("%0t: mismatch expected hit=%0b t=%0h actual hit=%0b t=%0h",
                             $time, expected_q[0].hit, expected_q[0].hit_distance,
                             res.hit, res.hit_distance);
                    fail_count <= fail_count + 1;
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
        end
    end
endmodule

### tb/ray_rectangle_intersect_test.sv
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_test
// Drives rays through several rectangle settings with random bursts, gaps and
// output stalls; the checker predicts every result and counts failures.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_test;
    import rri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 44;
    localparam int MAX_CYCLE = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic ray_valid = 1'b0;
    logic ray_stall;
    rri_in_t ray = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    rri_out_t res;
    int fail_count, pending, hit_count, result_count;
    int cycle = 0;
    int rays_sent = 0;
    bit hold_off = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ray_rectangle_intersect dut (.*);

    ray_rectangle_intersect_check checker_i (.*);

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("timeout at cycle %0d", cycle);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern; hold_off forces a long stretch
    always @(posedge clk)
    begin
        int mode;
        mode = (cycle / 2000) % 3;
        if (hold_off)
            res_stall <= 1'b1;
        else if (mode == 0)
            res_stall <= 1'b0;
        else if (mode == 1)
            res_stall <= ($urandom_range(0, 3) == 0);
        else
            res_stall <= ($urandom_range(0, 1) == 0);
    end

    function automatic logic [CFG_DATA_WIDTH-1:0] pack_vec(int x, int y, int z);
        return {COORD_WIDTH'(z), COORD_WIDTH'(y), COORD_WIDTH'(x)};
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_ray(rri_in_t item);
        ray_valid <= 1'b1;
        ray <= item;
        @(posedge clk);
        while (ray_stall)
            @(posedge clk);
        rays_sent++;
    endtask

    function automatic int rnd_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic rri_in_t aimed_ray(int span);
        rri_in_t r;
        // start in front of the plane z=0, point mostly toward it
        r.ray_start_x = COORD_WIDTH'(rnd_coord(span));
        r.ray_start_y = COORD_WIDTH'(rnd_coord(span));
        r.ray_start_z = COORD_WIDTH'($urandom_range(1, span));
        r.ray_dir_x = COORD_WIDTH'(rnd_coord(1024));
        r.ray_dir_y = COORD_WIDTH'(rnd_coord(1024));
        r.ray_dir_z = COORD_WIDTH'(-int'($urandom_range(1, 2048)));
        return r;
    endfunction

    task automatic random_phase(int count, bit noisy);
        int left, burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0)
            begin
                if (noisy && $urandom_range(0, 3) == 0)
                    send_ray(rri_in_t'({$urandom, $urandom, $urandom, $urandom}));
                else
                    send_ray(aimed_ray($urandom_range(0, 1) ? 4096 : 524287));
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                ray_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        ray_valid <= 1'b0;
    endtask

    task automatic set_rect(logic [CFG_DATA_WIDTH-1:0] c, logic [CFG_DATA_WIDTH-1:0] u,
                            logic [CFG_DATA_WIDTH-1:0] v, int eps);
        write_reg(REG_CENTER, c);
        write_reg(REG_HALF_U, u);
        write_reg(REG_HALF_V, v);
        write_reg(REG_EPSILON, CFG_DATA_WIDTH'(eps));
    endtask

    initial
    begin
        rri_in_t r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate rectangle at reset values: every ray misses
        send_ray('0);
        send_ray(aimed_ray(4096));
        ray_valid <= 1'b0;
        drain();

        // unit square on z=0, side 2.0
        set_rect('0, pack_vec(1024, 0, 0), pack_vec(0, 1024, 0), 1);
        r = '0;
        r.ray_start_z = 20'sd1024; r.ray_dir_z = -20'sd1024;
        send_ray(r);                              // straight hit, t=1
        r.ray_dir_z = 20'sd1024;  send_ray(r);    // behind start
        r.ray_dir_z = '0; r.ray_dir_x = 20'sd1024; send_ray(r); // parallel
        r = '0; r.ray_dir_z = -20'sd1;  send_ray(r);             // t=0, epsilon 1
        r.ray_start_z = 20'sd524287; r.ray_dir_z = -20'sd1; send_ray(r); // large t
        r.ray_start_x = 20'sd1024; r.ray_start_z = 20'sd1024; r.ray_dir_z = -20'sd1024;
        send_ray(r);                              // on the edge
        r.ray_start_x = 20'sd1022; send_ray(r);   // just inside
        send_ray(rri_in_t'({6{20'h80000}}));
        send_ray(rri_in_t'({6{20'h7ffff}}));
        send_ray(rri_in_t'({20'h80000, 20'h7ffff, 20'h80000, 20'h7ffff, 20'h80000, 20'h7ffff}));
        ray_valid <= 1'b0;
        drain();

        write_reg(REG_EPSILON, '0);
        r = '0; r.ray_dir_z = -20'sd1; send_ray(r); // t=0 passes with epsilon 0
        ray_valid <= 1'b0;
        drain();

        // long output hold while rays keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(120, 1'b0);
        join
        drain();

        set_rect(pack_vec(100, -200, 50), pack_vec(3000, 500, 0),
                 pack_vec(-300, 2500, 40), 1023);
        random_phase(300, 1'b1);
        drain();

        set_rect(pack_vec(-524288, 524287, -1), pack_vec(524287, 0, 0),
                 pack_vec(0, -524288, 0), 0);
        random_phase(150, 1'b1);
        drain();

        set_rect(pack_vec(0, 0, -2), pack_vec(20000, 0, 0), pack_vec(0, 15000, 0), 7);
        random_phase(400, 1'b0);
        drain();

        set_rect(CFG_DATA_WIDTH'({$urandom, $urandom}),
                 CFG_DATA_WIDTH'({$urandom, $urandom}),
                 CFG_DATA_WIDTH'({$urandom, $urandom}),
                 $urandom_range(0, 1023));
        random_phase(150, 1'b1);
        drain();

        set_rect('0, pack_vec(4096, 0, 0), pack_vec(0, 4096, 0), 3);
        random_phase(300, 1'b0);
        drain();

        $display("%0d rays over six rectangle settings, %0d results, %0d hits",
                 rays_sent, result_count, hit_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### ray_rectangle_intersect.f
design/rri_pkg.sv
design/rri_divider.sv
design/ray_rectangle_intersect.sv
design/rri_checker.sv
tb/ray_rectangle_intersect_check.sv
tb/ray_rectangle_intersect_test.sv
